[rtl/sem_pkg.sv]
`timescale 1ns / 1ps
// sem_pkg: shared widths, constants and types of the sobel edge magnitude block
// depends on nothing; imported by every other file of the block

package sem_pkg;

	localparam int PIX_W          = 8;
	localparam int ROW_W          = 12;
	localparam int COL_OUT_W      = 12;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int MAG_W          = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd1;

	// frame geometry limits
	localparam int WIDTH_MIN      = 3;
	localparam int COUNT_MIN      = 3;
	localparam int COUNT_MAX      = 4096;
	localparam int FIRST_INTERIOR = 2;

	// gradient and energy widths: |g| <= 1020, g*g < 2**20
	localparam int GRAD_W         = 11;
	localparam int SQ_W           = 20;
	localparam int ENERGY_W       = SQ_W + 1;
	localparam int SAT_LIMIT      = 65536;
	localparam int RAD_W          = 16;
	localparam int REM_W          = 9;
	localparam int SQRT_STEPS     = 8;
	localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

	// queue between front and back
	localparam int QDEPTH         = 4;
	localparam int QAW            = 2;
	localparam int QCW            = 3;

	typedef struct packed {
		logic [GRAD_W-1:0]    gx;
		logic [GRAD_W-1:0]    gy;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 frame_end;
	} sem_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 frame_end;
	} sem_meta_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           empty;
	} sem_qstat_t;

endpackage

[rtl/sem_pixel_if.sv]
`timescale 1ns / 1ps
// sem_pixel_if: pixel stream channel, valid/ready with pixel and frame start
// depends on sem_pkg

interface sem_pixel_if import sem_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, pixel, frame_start, input ready);
	modport sink   (input valid, pixel, frame_start, output ready);
endinterface

[rtl/sem_result_if.sv]
`timescale 1ns / 1ps
// sem_result_if: result channel, valid/ready with magnitude and position
// depends on sem_pkg

interface sem_result_if import sem_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [MAG_W-1:0]     magnitude;
	logic [ROW_W-1:0]     out_row;
	logic [COL_OUT_W-1:0] out_col;
	logic                 frame_end;

	modport source (output valid, magnitude, out_row, out_col, frame_end, input ready);
	modport sink   (input valid, magnitude, out_row, out_col, frame_end, output ready);
endinterface

[rtl/sem_cfg_if.sv]
`timescale 1ns / 1ps
// sem_cfg_if: configuration write channel, valid/ready with index and data
// depends on sem_pkg

interface sem_cfg_if import sem_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/sem_front.sv]
`timescale 1ns / 1ps
// sem_front: pixel acceptance, position tracking, line stores, 3x3 window, gradients
// depends on sem_pkg and sem_pixel_if; pushes gradient items into sem_queue

module sem_front import sem_pkg::*; #(
	parameter int MAX_LINE = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sem_pixel_if.sink             pixels,
	input  logic [$clog2(MAX_LINE+1)-1:0] width,
	input  logic [CFG_DATA_W-1:0] count,
	input  sem_qstat_t            qstat,
	output logic                  push,
	output sem_item_t             push_item
);

	localparam int CW = $clog2(MAX_LINE + 1);
	localparam int AW = $clog2(MAX_LINE);

	logic              accept;
	logic [ROW_W-1:0]  row_q;
	logic [CW-1:0]     col_q;
	logic [CFG_DATA_W-1:0] row_a;
	logic [CW-1:0]     col_a;
	logic [AW-1:0]     addr_a;
	logic              emit_a;
	logic              fe_a;

	logic              valid_s1;
	logic [PIX_W-1:0]  px_s1;
	logic              emit_s1;
	logic              fe_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_OUT_W-1:0] col_s1;
	logic [AW-1:0]     addr_s1;
	logic              fwd_s1;
	logic [PIX_W-1:0]  fwd_dat_s1;

	logic [PIX_W-1:0]  upper_mem  [MAX_LINE];
	logic [PIX_W-1:0]  middle_mem [MAX_LINE];
	logic [PIX_W-1:0]  up_rd_q;
	logic [PIX_W-1:0]  mid_rd_q;

	logic [PIX_W-1:0]  win_q [9];
	logic [PIX_W-1:0]  win_n [9];
	logic [PIX_W-1:0]  up_eff;
	logic [9:0]        gx_pos, gx_neg, gy_pos, gy_neg;

	// room for the item in s1 plus the new one
	assign pixels.ready = (qstat.count + QCW'(valid_s1)) < QCW'(QDEPTH);
	assign accept       = pixels.valid && pixels.ready;

	// position of the incoming pixel
	always_comb begin
		col_a = col_q;
		row_a = CFG_DATA_W'(row_q);
		if (pixels.frame_start) begin
			col_a = '0;
			row_a = '0;
		end
		if (col_a >= width) begin
			col_a = '0;
			row_a = row_a + CFG_DATA_W'(1);
		end
		if (row_a >= count) begin
			row_a = '0;
		end
		addr_a = col_a[AW-1:0];
		emit_a = (row_a >= CFG_DATA_W'(FIRST_INTERIOR)) && (col_a >= CW'(FIRST_INTERIOR));
		fe_a   = (row_a == count - CFG_DATA_W'(1)) && (col_a == width - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				row_q <= row_a[ROW_W-1:0];
				col_q <= col_a + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= pixels.pixel;
			emit_s1    <= emit_a;
			fe_s1      <= fe_a;
			row_s1     <= row_a[ROW_W-1:0] - ROW_W'(1);
			col_s1     <= COL_OUT_W'(col_a - CW'(1));
			addr_s1    <= addr_a;
			// upper store is written in the cycle after the read, so catch a read of that entry
			fwd_s1     <= valid_s1 && (addr_a == addr_s1);
			fwd_dat_s1 <= mid_rd_q;
		end
	end

	// middle store: read old value, write the new pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			mid_rd_q           <= middle_mem[addr_a];
			middle_mem[addr_a] <= pixels.pixel;
		end
	end

	// upper store: takes the middle value once it has been read
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_q <= upper_mem[addr_a];
		end
		if (valid_s1) begin
			upper_mem[addr_s1] <= mid_rd_q;
		end
	end

	assign up_eff = fwd_s1 ? fwd_dat_s1 : up_rd_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_n[k*3 + 0] = win_q[k*3 + 1];
			win_n[k*3 + 1] = win_q[k*3 + 2];
		end
		win_n[2] = up_eff;
		win_n[5] = mid_rd_q;
		win_n[8] = px_s1;
		gx_pos = 10'(win_n[2]) + (10'(win_n[5]) << 1) + 10'(win_n[8]);
		gx_neg = 10'(win_n[0]) + (10'(win_n[3]) << 1) + 10'(win_n[6]);
		gy_pos = 10'(win_n[0]) + (10'(win_n[1]) << 1) + 10'(win_n[2]);
		gy_neg = 10'(win_n[6]) + (10'(win_n[7]) << 1) + 10'(win_n[8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (valid_s1) begin
			win_q <= win_n;
		end
	end

	assign push = valid_s1 && emit_s1;

	always_comb begin
		push_item.gx        = GRAD_W'(gx_pos) - GRAD_W'(gx_neg);
		push_item.gy        = GRAD_W'(gy_pos) - GRAD_W'(gy_neg);
		push_item.row       = row_s1;
		push_item.col       = col_s1;
		push_item.frame_end = fe_s1;
	end

endmodule

[rtl/sem_queue.sv]
`timescale 1ns / 1ps
// sem_queue: short fifo of gradient items between front and back
// depends on sem_pkg

module sem_queue import sem_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sem_item_t  push_item,
	input  logic       pop,
	output sem_item_t  head,
	output sem_qstat_t qstat
);

	sem_item_t      slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head = slot_q[rd_ptr_q];

	always_comb begin
		qstat.count = count_q;
		qstat.empty = (count_q == '0);
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCW'(QDEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[QAW-1:0] == QAW'(wr_ptr_q - rd_ptr_q))
		else $error("queue fill count disagrees with pointers");

endmodule

[rtl/sem_back.sv]
`timescale 1ns / 1ps
// sem_back: squares, energy, clamped pipelined square root and result register
// depends on sem_pkg and sem_result_if; pops items from sem_queue

module sem_back import sem_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  sem_item_t    head,
	input  sem_qstat_t   qstat,
	output logic         pop,
	sem_result_if.source results
);

	localparam int NST = SQRT_STEPS;

	logic adv;

	logic signed [GRAD_W-1:0]   gx, gy;
	logic signed [2*GRAD_W-1:0] prod_x, prod_y;

	logic            v_s1;
	logic [SQ_W-1:0] sqx_s1, sqy_s1;
	sem_meta_t       meta_s1;
	logic [ENERGY_W-1:0] energy;

	// index 0 is the energy stage, 1..NST the root steps
	logic             sq_vld_s  [0:NST];
	logic [REM_W-1:0] sq_rem_s  [0:NST];
	logic [MAG_W-1:0] sq_root_s [0:NST];
	logic [RAD_W-1:0] sq_rad_s  [0:NST];
	logic             sq_sat_s  [0:NST];
	sem_meta_t        sq_meta_s [0:NST];

	logic [REM_W+1:0] acc   [1:NST];
	logic [REM_W+1:0] trial [1:NST];
	logic             take  [1:NST];

	// whole pipeline holds while a result waits
	assign adv = !sq_vld_s[NST] || results.ready;
	assign pop = adv && !qstat.empty;

	assign gx     = $signed(head.gx);
	assign gy     = $signed(head.gy);
	assign prod_x = gx * gx;
	assign prod_y = gy * gy;
	assign energy = ENERGY_W'(sqx_s1) + ENERGY_W'(sqy_s1);

	always_comb begin
		for (int k = 1; k <= NST; k++) begin
			acc[k]   = {sq_rem_s[k-1], sq_rad_s[k-1][RAD_W-1 -: 2]};
			trial[k] = (REM_W+2)'({sq_root_s[k-1], 2'b01});
			take[k]  = (acc[k] >= trial[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= NST; k++) begin
				sq_vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1        <= pop;
			sq_vld_s[0] <= v_s1;
			for (int k = 1; k <= NST; k++) begin
				sq_vld_s[k] <= sq_vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1            <= prod_x[SQ_W-1:0];
			sqy_s1            <= prod_y[SQ_W-1:0];
			meta_s1.row       <= head.row;
			meta_s1.col       <= head.col;
			meta_s1.frame_end <= head.frame_end;

			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_rad_s[0]  <= energy[RAD_W-1:0];
			sq_sat_s[0]  <= (energy >= ENERGY_W'(SAT_LIMIT));
			sq_meta_s[0] <= meta_s1;

			for (int k = 1; k <= NST; k++) begin
				sq_rem_s[k]  <= take[k] ? REM_W'(acc[k] - trial[k]) : REM_W'(acc[k]);
				sq_root_s[k] <= {sq_root_s[k-1][MAG_W-2:0], take[k]};
				sq_rad_s[k]  <= sq_rad_s[k-1] << 2;
				sq_sat_s[k]  <= sq_sat_s[k-1];
				sq_meta_s[k] <= sq_meta_s[k-1];
			end
		end
	end

	assign results.valid     = sq_vld_s[NST];
	assign results.magnitude = sq_sat_s[NST] ? MAG_MAX : sq_root_s[NST];
	assign results.out_row   = sq_meta_s[NST].row;
	assign results.out_col   = sq_meta_s[NST].col;
	assign results.frame_end = sq_meta_s[NST].frame_end;

endmodule

[rtl/sobel_edge_magnitude_top.sv]
`timescale 1ns / 1ps
// sobel_edge_magnitude_top: configuration registers and the front, queue and back
// depends on sem_pkg, the three channel interfaces, sem_front, sem_queue, sem_back

// sobel 3x3 edge magnitude over a row-major greyscale pixel stream
// channels:
//   pixels  - sink, one pixel per transaction, frame_start on a frame's first pixel
//   results - source, one transaction per interior pixel: magnitude, row, column,
//             frame_end on the last interior pixel of the frame; borders give none
//   cfg     - write channel, index 0 line width, index 1 line count, always ready;
//             values are clamped on write; write only while the block is idle
// throughput: one pixel per clock while pixels.ready is high; the line store
//   accesses are made in the accept cycle and the root pipeline does one step per stage
// path: a pixel's result passes the window stage, the queue, the squares, the energy
//   stage and the 8 root steps
// reset: position restarts at row 0, column 0, width and count return to their
//   maximum, pipeline and queue empty; line stores are not cleared, the first
//   two rows of a frame fill them before any read is used
// receiver stall: the result register and the whole back pipeline hold, the
//   4-entry queue absorbs in-flight items, then pixels.ready drops

module sobel_edge_magnitude_top import sem_pkg::*; #(
	parameter int MAX_LINE = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	sem_pixel_if.sink    pixels,
	sem_result_if.source results,
	sem_cfg_if.sink      cfg
);

	localparam int CW        = $clog2(MAX_LINE + 1);
	localparam int CMP_W     = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
	localparam int WIDTH_RST = (MAX_LINE < COUNT_MAX) ? MAX_LINE : COUNT_MAX;

	logic [CW-1:0]         width_q;
	logic [CFG_DATA_W-1:0] count_q;
	logic [CMP_W-1:0]      cfg_ext;

	logic       push;
	logic       pop;
	sem_item_t  push_item;
	sem_item_t  head;
	sem_qstat_t qstat;

	// register writes never stall
	assign cfg.ready = 1'b1;
	assign cfg_ext   = CMP_W'(cfg.data);

	// effective geometry kept already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CW'(WIDTH_RST);
			count_q <= CFG_DATA_W'(COUNT_MAX);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LINE_WIDTH: begin
					if (cfg_ext < CMP_W'(WIDTH_MIN)) begin
						width_q <= CW'(WIDTH_MIN);
					end else if (cfg_ext > CMP_W'(MAX_LINE)) begin
						width_q <= CW'(MAX_LINE);
					end else begin
						width_q <= CW'(cfg_ext);
					end
				end
				CFG_LINE_COUNT: begin
					if (cfg.data < CFG_DATA_W'(COUNT_MIN)) begin
						count_q <= CFG_DATA_W'(COUNT_MIN);
					end else if (cfg.data > CFG_DATA_W'(COUNT_MAX)) begin
						count_q <= CFG_DATA_W'(COUNT_MAX);
					end else begin
						count_q <= cfg.data;
					end
				end
				default: begin
					// unused index, write is dropped
				end
			endcase
		end
	end

	// front: takes pixels, keeps line stores and window, forms gradients
	sem_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.width     (width_q),
		.count     (count_q),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	// queue decouples the two halves
	sem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// back: energy, clamped square root, result register
	sem_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.results (results)
	);

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench of sobel_edge_magnitude_top, a sobel edge magnitude stream
// depends on sem_pkg, sem_pixel_if, sem_result_if, sem_cfg_if and the rtl of the block

module tb_top;
	import sem_pkg::*;

	localparam int LINE_MAX      = 4096;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int RANDOM_ITEMS  = 900;
	localparam int STRIP_ITEMS   = 160;
	localparam int WIDE_ITEMS    = 64;
	localparam int PRINT_LIMIT   = 30;

	typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_BINARY} pixel_style_e;

	typedef struct {
		logic [MAG_W-1:0]     magnitude;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 frame_end;
	} edge_result_t;

	// predictor of the block plus the store of magnitudes still owed by it
	class magnitude_scoreboard;
		logic [CFG_DATA_W-1:0] width_reg;
		logic [CFG_DATA_W-1:0] count_reg;
		logic [PIX_W-1:0]      upper_line [LINE_MAX];
		logic [PIX_W-1:0]      middle_line [LINE_MAX];
		logic [PIX_W-1:0]      win [9];
		int unsigned           row_pos;
		int unsigned           col_pos;
		edge_result_t          pending_magnitudes [$];
		int unsigned           mismatches;
		int unsigned           pixels_seen;
		int unsigned           results_seen;
		int unsigned           frame_ends_seen;

		function new();
			width_reg = CFG_DATA_W'(LINE_MAX);
			count_reg = CFG_DATA_W'(COUNT_MAX);
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			row_pos = 0;
			col_pos = 0;
			mismatches = 0;
			pixels_seen = 0;
			results_seen = 0;
			frame_ends_seen = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_LINE_WIDTH: width_reg = value;
				CFG_LINE_COUNT: count_reg = value;
				default: ;
			endcase
		endfunction

		// one accepted pixel: advance position, line stores and window, owe a result if interior
		function void take_pixel(logic [PIX_W-1:0] px, logic fs);
			int unsigned  w_eff, n_eff, r, c, p, root, trial, bitv, k;
			int           gx, gy;
			logic [PIX_W-1:0] up, mid;
			edge_result_t owed;
			pixels_seen++;
			w_eff = (width_reg < WIDTH_MIN) ? WIDTH_MIN :
			        (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
			n_eff = (count_reg < COUNT_MIN) ? COUNT_MIN :
			        (count_reg > COUNT_MAX) ? COUNT_MAX : count_reg;
			if (fs) begin
				row_pos = 0;
				col_pos = 0;
			end
			if (col_pos >= w_eff) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos >= n_eff) row_pos = 0;
			r = row_pos;
			c = col_pos;
			up = upper_line[c];
			mid = middle_line[c];
			upper_line[c] = mid;
			middle_line[c] = px;
			for (k = 0; k < 3; k++) begin
				win[k*3]     = win[k*3 + 1];
				win[k*3 + 1] = win[k*3 + 2];
			end
			win[2] = up;
			win[5] = mid;
			win[8] = px;
			col_pos = c + 1;
			if (r < FIRST_INTERIOR || c < FIRST_INTERIOR) return;
			gx = (int'(win[2]) + 2*int'(win[5]) + int'(win[8]))
			   - (int'(win[0]) + 2*int'(win[3]) + int'(win[6]));
			gy = (int'(win[0]) + 2*int'(win[1]) + int'(win[2]))
			   - (int'(win[6]) + 2*int'(win[7]) + int'(win[8]));
			p = gx*gx + gy*gy;
			if (p >= SAT_LIMIT) begin
				root = MAG_MAX;
			end else begin
				root = 0;
				for (bitv = 128; bitv != 0; bitv = bitv >> 1) begin
					trial = root | bitv;
					if (trial*trial <= p) root = trial;
				end
			end
			owed.magnitude = MAG_W'(root);
			owed.row = ROW_W'(r - 1);
			owed.col = COL_OUT_W'(c - 1);
			owed.frame_end = (r == n_eff - 1) && (c == w_eff - 1);
			pending_magnitudes.push_back(owed);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= PRINT_LIMIT)
				$display("mismatch %0d at %0t ns: %s", mismatches, $time, what);
		endtask

		task check_result(logic [MAG_W-1:0] mag, logic [ROW_W-1:0] row,
		                  logic [COL_OUT_W-1:0] col, logic fe);
			edge_result_t owed;
			if (pending_magnitudes.size() == 0) begin
				report_mismatch($sformatf("unexpected result row %0d col %0d magnitude %0d",
				                          row, col, mag));
				return;
			end
			owed = pending_magnitudes.pop_front();
			results_seen++;
			if (fe === 1'b1) frame_ends_seen++;
			if (mag !== owed.magnitude)
				report_mismatch($sformatf("magnitude %0d, expected %0d (row %0d col %0d)",
				                          mag, owed.magnitude, owed.row, owed.col));
			if (row !== owed.row)
				report_mismatch($sformatf("out_row %0d, expected %0d", row, owed.row));
			if (col !== owed.col)
				report_mismatch($sformatf("out_col %0d, expected %0d", col, owed.col));
			if (fe !== owed.frame_end)
				report_mismatch($sformatf("frame_end %b, expected %b (row %0d col %0d)",
				                          fe, owed.frame_end, owed.row, owed.col));
		endtask

		task flush_pending();
			edge_result_t owed;
			while (pending_magnitudes.size() != 0) begin
				owed = pending_magnitudes.pop_front();
				report_mismatch($sformatf("missing result row %0d col %0d", owed.row, owed.col));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	sem_pixel_if  pix_ch ();
	sem_result_if res_ch ();
	sem_cfg_if    cfg_ch ();

	sobel_edge_magnitude_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	magnitude_scoreboard board;
	int unsigned         send_idle_pct = 38;
	int unsigned         recv_stall_pct = 52;
	int unsigned         config_writes = 0;
	int                  smooth_level = 128;

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver side: ready drops at random with the current stall rate
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watch both channels; every pixel transaction feeds the predictor, every
	// result transaction is matched against the oldest owed magnitude
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (pix_ch.valid && pix_ch.ready)
				board.take_pixel(pix_ch.pixel, pix_ch.frame_start);
			if (res_ch.valid && res_ch.ready)
				board.check_result(res_ch.magnitude, res_ch.out_row, res_ch.out_col,
				                   res_ch.frame_end);
		end
	end

	// one register write transaction; valid is left high for a following write
	task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		board.write_register(idx, CFG_DATA_W'(value));
		config_writes++;
	endtask

	// only called while the block is idle
	task automatic apply_geometry(input logic set_w, input int unsigned w,
	                              input logic set_n, input int unsigned n);
		if (set_w) cfg_transfer(CFG_LINE_WIDTH, w);
		if (set_n) cfg_transfer(CFG_LINE_COUNT, n);
		cfg_ch.valid <= 1'b0;
	endtask

	// one pixel transaction, preceded by a random run of idle cycles
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= px;
		pix_ch.frame_start <= fs;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// wait for every owed result (bounded), then let the pipeline empty out;
	// a clock edge first so the monitor has noted the last pixel transaction
	task automatic settle_block();
		int unsigned waited;
		waited = 0;
		@(posedge clk);
		while (board.pending_magnitudes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		board.flush_pending();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic finish_stream();
		pix_ch.valid <= 1'b0;
		settle_block();
	endtask

	function automatic logic [PIX_W-1:0] make_pixel(input pixel_style_e style);
		int v;
		case (style)
			STYLE_SMOOTH: begin
				// slow drift gives small gradients and exercises the low roots
				smooth_level = smooth_level + int'($urandom_range(8)) - 4;
				if (smooth_level < 0) smooth_level = 0;
				if (smooth_level > 255) smooth_level = 255;
				v = smooth_level;
			end
			STYLE_BINARY: v = $urandom_range(1) ? 255 : 0;
			default: v = $urandom_range(255);
		endcase
		return PIX_W'(v);
	endfunction

	// a stream of pixels; lead_start marks the first one, restart_odds (0 = never)
	// sprinkles stray frame starts that cut frames short
	task automatic run_stream(input int unsigned n_items, input pixel_style_e style,
	                          input logic lead_start, input int unsigned restart_odds);
		logic fs;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i == 0) fs = lead_start;
			else fs = (restart_odds != 0) && ($urandom_range(restart_odds - 1) == 0);
			send_pixel(make_pixel(style), fs);
		end
		finish_stream();
	endtask

	initial begin
		int unsigned  random_items, w, n, w_eff, n_eff, n_items, odds;
		pixel_style_e style;
		board = new();
		pix_ch.valid <= 1'b0;
		pix_ch.pixel <= '0;
		pix_ch.frame_start <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_LINE_WIDTH;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest frame, both registers written below minimum so they clamp to 3
		apply_geometry(1'b1, 0, 1'b1, 1);
		// right column of 64s: gradient energy exactly 65536, must saturate
		for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? PIX_W'(64) : PIX_W'(0), i == 0);
		// no frame start: position wraps into a new frame; single corner pixel gives root 12
		for (int i = 0; i < 9; i++) send_pixel((i == 2) ? PIX_W'(9) : PIX_W'(0), 1'b0);
		// a frame cut short after one pixel, then a flat frame of full-scale pixels
		send_pixel(PIX_W'(170), 1'b1);
		for (int i = 0; i < 9; i++) send_pixel(PIX_W'(255), i == 0);
		finish_stream();

		// position beyond a shrunken size: stop at row 3 col 5 of an 8x8 frame,
		// narrow to 5 columns (next pixel opens row 4), then cut rows to 4 (wraps to row 0)
		apply_geometry(1'b1, 8, 1'b1, 8);
		run_stream(29, STYLE_NOISE, 1'b1, 0);
		apply_geometry(1'b1, 5, 1'b0, 0);
		run_stream(15, STYLE_NOISE, 1'b0, 0);
		apply_geometry(1'b0, 0, 1'b1, 4);
		run_stream(30, STYLE_BINARY, 1'b0, 0);

		// random frames of small geometry; idling swaps sides after the first third, none in the last
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 38;
				recv_stall_pct = 52;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 52;
				recv_stall_pct = 38;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			case ($urandom_range(19))
				0, 1:    w = $urandom_range(2);
				2, 3, 4: w = $urandom_range(24, 13);
				default: w = $urandom_range(12, 3);
			endcase
			n = ($urandom_range(9) < 2) ? $urandom_range(2) : $urandom_range(8, 3);
			w_eff = (w < WIDTH_MIN) ? WIDTH_MIN : w;
			n_eff = (n < COUNT_MIN) ? COUNT_MIN : n;
			n_items = w_eff * n_eff * $urandom_range(3, 1) + $urandom_range(2 * w_eff);
			odds = ($urandom_range(3) == 0) ? 40 : 0;
			style = pixel_style_e'($urandom_range(2));
			apply_geometry(1'b1, w, 1'b1, n);
			run_stream(n_items, style, 1'b1, odds);
			random_items += n_items;
		end

		// widest line: the opening pixels of a 4096-wide frame
		apply_geometry(1'b1, LINE_MAX, 1'b1, 0);
		run_stream(WIDE_ITEMS, STYLE_NOISE, 1'b1, 0);
		// tallest frame, count written past its maximum: a narrow strip of its top rows
		apply_geometry(1'b1, 4, 1'b1, 8191);
		run_stream(STRIP_ITEMS, STYLE_SMOOTH, 1'b1, 0);
		// width written past its maximum
		apply_geometry(1'b1, 8191, 1'b1, 3);
		run_stream(WIDE_ITEMS, STYLE_BINARY, 1'b1, 0);

		$display("run covered %0d pixel and %0d result transactions, %0d frame ends",
		         board.pixels_seen, board.results_seen, board.frame_ends_seen);
		$display("over %0d register writes, line widths 3..4096 and line counts 3..4096",
		         config_writes);
		if (board.mismatches == 0) begin
			$display("** sobel_edge_magnitude_top: PASSED **");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("** sobel_edge_magnitude_top: FAILED **");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("timeout: stimulus or results stalled");
		$display("** sobel_edge_magnitude_top: FAILED **");
		$finish;
	end

endmodule
